### rtl/core/qfpc_pkg.sv
package qfpc_pkg;

  localparam int MAX_VERSION_DEF = 40;

  localparam int VER_W   = 6;
  localparam int COORD_W = 8;
  localparam int STEP_W  = 5;
  localparam int COLS_W  = 3;
  localparam int OFF_W   = 2;

  typedef enum logic [2:0] {
    KIND_NONE      = 3'd0,
    KIND_FINDER    = 3'd1,
    KIND_SEPARATOR = 3'd2,
    KIND_TIMING    = 3'd3,
    KIND_ALIGN     = 3'd4
  } kind_t;

  // Symbol geometry that follows from the version register
  typedef struct packed {
    logic [COORD_W-1:0] side;
    logic [COLS_W-1:0]  cols;
    logic               align_en;
  } geom_t;

  // Control carried from the locate stage to the resolve stage
  typedef struct packed {
    logic  valid;
    logic  outside;
    kind_t kind;
    logic  dark;
  } s2_ctl_t;

  // Alignment grid pitch: len/(cols-1) rounded half away, bumped up to even
  function automatic logic [STEP_W-1:0] step_for_version(input logic [VER_W-1:0] v);
    logic [STEP_W-1:0] s;
    unique case (v)
      6'd2:                                            s = 5'd12;
      6'd3, 6'd7:                                      s = 5'd16;
      6'd8:                                            s = 5'd18;
      6'd4, 6'd9, 6'd14:                               s = 5'd20;
      6'd10, 6'd15, 6'd21:                             s = 5'd22;
      6'd5, 6'd11, 6'd16, 6'd17, 6'd22, 6'd23,
      6'd28, 6'd29, 6'd35:                             s = 5'd24;
      6'd12, 6'd18, 6'd24, 6'd25, 6'd30, 6'd31,
      6'd32, 6'd36, 6'd37, 6'd38:                      s = 5'd26;
      6'd6, 6'd13, 6'd19, 6'd20, 6'd26, 6'd27,
      6'd33, 6'd34, 6'd39, 6'd40:                      s = 5'd28;
      default:                                         s = 5'd0;
    endcase
    return s;
  endfunction

  // Number of alignment grid columns: v/7 + 2
  function automatic logic [COLS_W-1:0] cols_for_version(input logic [VER_W-1:0] v);
    logic [COLS_W-1:0] c;
    c = 3'd2 + COLS_W'(v >= 6'd7) + COLS_W'(v >= 6'd14) + COLS_W'(v >= 6'd21)
        + COLS_W'(v >= 6'd28) + COLS_W'(v >= 6'd35);
    return c;
  endfunction

  // Finder color at local position (a, b) in 0..6
  function automatic logic finder_dark(input logic [2:0] a, input logic [2:0] b);
    logic [2:0] da;
    logic [2:0] db;
    da = (a >= 3'd3) ? a - 3'd3 : 3'd3 - a;
    db = (b >= 3'd3) ? b - 3'd3 : 3'd3 - b;
    return ((da > db) ? da : db) != 3'd2;
  endfunction

endpackage

### rtl/core/qfpc_cfg.sv
module qfpc_cfg
  import qfpc_pkg::*;
#(
  parameter int MAX_VERSION = MAX_VERSION_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [VER_W-1:0]                      cfg_data,
  output logic                                  busy,
  output geom_t                                 geom,
  output logic [MAX_VERSION/7+1:0][COORD_W-1:0] centre
);

  localparam int GridMax = MAX_VERSION / 7 + 2;

  logic [VER_W-1:0]                   version_r;
  logic [VER_W-1:0]                   ver_eff;
  logic [STEP_W-1:0]                  step;
  logic [COORD_W-1:0]                 base;
  geom_t                              geom_r;
  geom_t                              geom_nxt;
  logic [GridMax-1:0][COORD_W-1:0]    centre_r;
  logic [GridMax-1:0][COORD_W-1:0]    centre_nxt;
  logic                               busy_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      version_r <= VER_W'(1);
      busy_r    <= 1'b1;
    end else begin
      busy_r <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        version_r <= cfg_data;
      end
    end
  end

  always_comb begin
    priority if (version_r == '0) begin
      ver_eff = VER_W'(1);
    end else if (version_r > VER_W'(MAX_VERSION)) begin
      ver_eff = VER_W'(MAX_VERSION);
    end else begin
      ver_eff = version_r;
    end
  end

  assign step = step_for_version(ver_eff);
  assign base = {ver_eff, 2'b00} + COORD_W'(10);

  always_comb begin
    geom_nxt.side     = {ver_eff, 2'b00} + COORD_W'(17);
    geom_nxt.cols     = cols_for_version(ver_eff);
    geom_nxt.align_en = ver_eff > VER_W'(1);
    for (int k = 0; k < GridMax; k++) begin
      if (k == 0) begin
        centre_nxt[k] = COORD_W'(6);
      end else begin
        // count centres back from the far edge
        centre_nxt[k] = base - COORD_W'(COORD_W'(geom_nxt.cols - COLS_W'(1) - COLS_W'(k))
                                        * COORD_W'(step));
      end
    end
  end

  // Geometry is registered from the version register; coordinates are not held
  // off while it follows a version write.
  always_ff @(posedge clk) begin
    geom_r   <= geom_nxt;
    centre_r <= centre_nxt;
  end

  assign busy   = busy_r;
  assign geom   = geom_r;
  assign centre = centre_r;

endmodule

### rtl/core/qfpc_locate.sv
module qfpc_locate
  import qfpc_pkg::*;
#(
  parameter int MAX_VERSION = MAX_VERSION_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_take,
  input  logic [COORD_W-1:0]                    in_col,
  input  logic [COORD_W-1:0]                    in_row,
  input  geom_t                                 geom,
  input  logic [MAX_VERSION/7+1:0][COORD_W-1:0] centre,
  output s2_ctl_t                               s2_ctl,
  output logic [MAX_VERSION/7+1:0]              col_hit,
  output logic [MAX_VERSION/7+1:0][OFF_W-1:0]   col_off,
  output logic [MAX_VERSION/7+1:0]              row_hit,
  output logic [MAX_VERSION/7+1:0][OFF_W-1:0]   row_off
);

  localparam int GridMax = MAX_VERSION / 7 + 2;

  logic                              s1_valid_r;
  logic [COORD_W-1:0]                s1_col_r;
  logic [COORD_W-1:0]                s1_row_r;

  s2_ctl_t                           ctl_nxt;
  logic [GridMax-1:0]                col_hit_nxt;
  logic [GridMax-1:0][OFF_W-1:0]     col_off_nxt;
  logic [GridMax-1:0]                row_hit_nxt;
  logic [GridMax-1:0][OFF_W-1:0]     row_off_nxt;

  s2_ctl_t                           s2_ctl_r;
  logic [GridMax-1:0]                col_hit_r;
  logic [GridMax-1:0][OFF_W-1:0]     col_off_r;
  logic [GridMax-1:0]                row_hit_r;
  logic [GridMax-1:0][OFF_W-1:0]     row_off_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= in_take;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_col_r <= in_col;
      s1_row_r <= in_row;
    end
  end

  // Base classification: finder, separator, timing
  always_comb begin
    logic [COORD_W-1:0] side_m8;
    logic [COORD_W-1:0] tc;
    logic [COORD_W-1:0] tr;
    logic               c_lo;
    logic               r_lo;
    logic [2:0]         fa;
    logic [2:0]         fb;
    logic               fin;
    logic               corner;

    side_m8 = geom.side - COORD_W'(8);
    tc      = s1_col_r - side_m8;
    tr      = s1_row_r - side_m8;
    c_lo    = s1_col_r < COORD_W'(8);
    r_lo    = s1_row_r < COORD_W'(8);
    fa      = s1_col_r[2:0];
    fb      = s1_row_r[2:0];
    fin     = 1'b0;
    corner  = 1'b1;

    priority if (c_lo && r_lo) begin
      fin = (s1_col_r < COORD_W'(7)) && (s1_row_r < COORD_W'(7));
    end else if (s1_col_r >= side_m8 && r_lo) begin
      fin = (tc[2:0] != 3'd0) && (s1_row_r < COORD_W'(7));
      fa  = tc[2:0] - 3'd1;
    end else if (c_lo && s1_row_r >= side_m8) begin
      fin = (tr[2:0] != 3'd0) && (s1_col_r < COORD_W'(7));
      fb  = tr[2:0] - 3'd1;
    end else begin
      corner = 1'b0;
    end

    ctl_nxt.valid   = s1_valid_r;
    ctl_nxt.outside = (s1_col_r >= geom.side) || (s1_row_r >= geom.side);
    ctl_nxt.kind    = KIND_NONE;
    ctl_nxt.dark    = 1'b0;

    priority if (ctl_nxt.outside) begin
      ctl_nxt.kind = KIND_NONE;
    end else if (corner && fin) begin
      ctl_nxt.kind = KIND_FINDER;
      ctl_nxt.dark = finder_dark(fa, fb);
    end else if (corner) begin
      ctl_nxt.kind = KIND_SEPARATOR;
    end else if (s1_row_r == COORD_W'(6) && !c_lo && s1_col_r < side_m8) begin
      ctl_nxt.kind = KIND_TIMING;
      ctl_nxt.dark = ~s1_col_r[0];
    end else if (s1_col_r == COORD_W'(6) && !r_lo && s1_row_r < side_m8) begin
      ctl_nxt.kind = KIND_TIMING;
      ctl_nxt.dark = ~s1_row_r[0];
    end else begin
      ctl_nxt.kind = KIND_NONE;
    end
  end

  // Distance from each alignment centre, one axis at a time
  always_comb begin
    logic [COORD_W-1:0] dc;
    logic [COORD_W-1:0] dr;
    for (int k = 0; k < GridMax; k++) begin
      dc = (s1_col_r >= centre[k]) ? s1_col_r - centre[k] : centre[k] - s1_col_r;
      dr = (s1_row_r >= centre[k]) ? s1_row_r - centre[k] : centre[k] - s1_row_r;
      col_hit_nxt[k] = dc <= COORD_W'(2);
      col_off_nxt[k] = dc[OFF_W-1:0];
      row_hit_nxt[k] = dr <= COORD_W'(2);
      row_off_nxt[k] = dr[OFF_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_ctl_r.valid <= 1'b0;
    end else begin
      s2_ctl_r.valid <= ctl_nxt.valid;
    end
    s2_ctl_r.outside <= ctl_nxt.outside;
    s2_ctl_r.kind    <= ctl_nxt.kind;
    s2_ctl_r.dark    <= ctl_nxt.dark;
    col_hit_r        <= col_hit_nxt;
    col_off_r        <= col_off_nxt;
    row_hit_r        <= row_hit_nxt;
    row_off_r        <= row_off_nxt;
  end

  assign s2_ctl  = s2_ctl_r;
  assign col_hit = col_hit_r;
  assign col_off = col_off_r;
  assign row_hit = row_hit_r;
  assign row_off = row_off_r;

endmodule

### rtl/core/qfpc_resolve.sv
module qfpc_resolve
  import qfpc_pkg::*;
#(
  parameter int MAX_VERSION = MAX_VERSION_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  geom_t                               geom,
  input  s2_ctl_t                             s2_ctl,
  input  logic [MAX_VERSION/7+1:0]            col_hit,
  input  logic [MAX_VERSION/7+1:0][OFF_W-1:0] col_off,
  input  logic [MAX_VERSION/7+1:0]            row_hit,
  input  logic [MAX_VERSION/7+1:0][OFF_W-1:0] row_off,
  output logic                                out_valid,
  output logic                                out_reserved,
  output logic                                out_dark,
  output logic [2:0]                          out_kind,
  output logic                                out_outside
);

  localparam int GridMax = MAX_VERSION / 7 + 2;

  logic  align_hit;
  logic  align_dark;
  kind_t kind_nxt;
  logic  dark_nxt;

  logic  valid_r;
  kind_t kind_r;
  logic  dark_r;
  logic  outside_r;

  // Scan grid pairs in column-major order; a later match wins
  always_comb begin
    logic [COLS_W-1:0] last;
    logic              use_pair;
    logic [OFF_W-1:0]  ox;
    logic [OFF_W-1:0]  oy;
    last       = geom.cols - COLS_W'(1);
    align_hit  = 1'b0;
    align_dark = 1'b0;
    for (int x = 0; x < GridMax; x++) begin
      for (int y = 0; y < GridMax; y++) begin
        use_pair = geom.align_en && (COLS_W'(x) < geom.cols) && (COLS_W'(y) < geom.cols)
                   && !(x == 0 && y == 0)
                   && !(x == 0 && COLS_W'(y) == last)
                   && !(COLS_W'(x) == last && y == 0);
        ox = col_off[x];
        oy = row_off[y];
        if (use_pair && col_hit[x] && row_hit[y]) begin
          align_hit  = 1'b1;
          // light only on the ring at distance one
          align_dark = !((ox == 2'd1 && oy <= 2'd1) || (oy == 2'd1 && ox <= 2'd1));
        end
      end
    end
  end

  always_comb begin
    priority if (s2_ctl.outside) begin
      kind_nxt = KIND_NONE;
      dark_nxt = 1'b0;
    end else if (align_hit) begin
      kind_nxt = KIND_ALIGN;
      dark_nxt = align_dark;
    end else begin
      kind_nxt = s2_ctl.kind;
      dark_nxt = s2_ctl.dark;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= s2_ctl.valid;
    end
  end

  always_ff @(posedge clk) begin
    kind_r    <= kind_nxt;
    dark_r    <= dark_nxt;
    outside_r <= s2_ctl.outside;
  end

  assign out_valid    = valid_r;
  assign out_kind     = kind_r;
  assign out_reserved = kind_r != KIND_NONE;
  assign out_dark     = (kind_r != KIND_NONE) && dark_r;
  assign out_outside  = outside_r;

  a_outside_clear: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_outside |-> !out_reserved && !out_dark && out_kind == KIND_NONE)
    else $error("outside coordinate reported as a pattern");

  a_dark_reserved: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_dark |-> out_reserved)
    else $error("dark module outside any pattern");

  a_valid_follows: assert property (@(posedge clk) disable iff (!rst_n)
    s2_ctl.valid |=> out_valid)
    else $error("resolve stage dropped a transaction");

endmodule

### rtl/core/qr_function_pattern_classifier.sv
// Channel   Ports                                         Handshake
// input     in_col, in_row                                start & !busy
// result    out_reserved, out_dark, out_kind, out_outside out_valid strobe, one cycle
// config    cfg_data (version)                            cfg_valid & cfg_ready
//
// One coordinate is accepted per clock while busy is low; its result is registered
// through the input, locate and resolve register stages.
// Synchronous active-low reset sets version 1; busy stays high through reset
// and the cycle after it while the grid geometry loads.
// cfg_ready is always high; a version write loads version_r, and the derived
// geometry is registered from it. The receiver cannot stall, so nothing backs up.
module qr_function_pattern_classifier
  import qfpc_pkg::*;
#(
  parameter int MAX_VERSION = MAX_VERSION_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [COORD_W-1:0] in_col,
  input  logic [COORD_W-1:0] in_row,
  output logic               out_valid,
  output logic               out_reserved,
  output logic               out_dark,
  output logic [2:0]         out_kind,
  output logic               out_outside,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [VER_W-1:0]   cfg_data
);

  localparam int GridMax = MAX_VERSION / 7 + 2;

  geom_t                           geom;
  logic [GridMax-1:0][COORD_W-1:0] centre;
  s2_ctl_t                         s2_ctl;
  logic [GridMax-1:0]              col_hit;
  logic [GridMax-1:0][OFF_W-1:0]   col_off;
  logic [GridMax-1:0]              row_hit;
  logic [GridMax-1:0][OFF_W-1:0]   row_off;
  logic                            in_take;

  assign in_take = start && !busy;

  qfpc_cfg #(.MAX_VERSION(MAX_VERSION)) u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .busy      (busy),
    .geom      (geom),
    .centre    (centre)
  );

  qfpc_locate #(.MAX_VERSION(MAX_VERSION)) u_locate (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_take (in_take),
    .in_col  (in_col),
    .in_row  (in_row),
    .geom    (geom),
    .centre  (centre),
    .s2_ctl  (s2_ctl),
    .col_hit (col_hit),
    .col_off (col_off),
    .row_hit (row_hit),
    .row_off (row_off)
  );

  qfpc_resolve #(.MAX_VERSION(MAX_VERSION)) u_resolve (
    .clk          (clk),
    .rst_n        (rst_n),
    .geom         (geom),
    .s2_ctl       (s2_ctl),
    .col_hit      (col_hit),
    .col_off      (col_off),
    .row_hit      (row_hit),
    .row_off      (row_off),
    .out_valid    (out_valid),
    .out_reserved (out_reserved),
    .out_dark     (out_dark),
    .out_kind     (out_kind),
    .out_outside  (out_outside)
  );

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_take |-> ##3 out_valid)
    else $error("accepted transaction did not produce a result");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(in_take, 3))
    else $error("result without an accepted transaction");

endmodule
